// ===== rtl/dmrs_pkg.sv =====
// Package for the debounced motor relay sequencer.
// Holds widths, phase and register codes, the configuration and result structs.
// No dependencies; every other file imports it.
package dmrs_pkg;

  localparam int TIMER_W    = 16;
  localparam int DEB_W      = 10;
  localparam int DLY_W      = 16;
  localparam int PW_W       = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // Compare width that holds both a timer and the widest delay register.
  localparam int CMP_W      = (TIMER_W > DLY_W) ? TIMER_W : DLY_W;

  typedef logic [TIMER_W-1:0] timer_t;
  typedef logic [CMP_W-1:0]   cmp_t;

  localparam timer_t TMR_MAX = {TIMER_W{1'b1}};

  localparam logic [PW_W-1:0] ESC_W_MIN = PW_W'(1000);
  localparam logic [PW_W-1:0] ESC_W_MAX = PW_W'(2000);

  localparam logic [DEB_W-1:0] RST_DEBOUNCE  = DEB_W'(30);
  localparam logic [DLY_W-1:0] RST_ON_DELAY  = DLY_W'(300);
  localparam logic [DLY_W-1:0] RST_OFF_DELAY = DLY_W'(300);
  localparam logic [DLY_W-1:0] RST_ARM       = DLY_W'(3000);
  localparam logic [PW_W-1:0]  RST_ESC_STOP  = PW_W'(1000);
  localparam logic [PW_W-1:0]  RST_ESC_RUN   = PW_W'(2000);
  localparam logic             RST_RELAY_LVL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE    = 3'd0,
    CFG_ON_DELAY    = 3'd1,
    CFG_OFF_DELAY   = 3'd2,
    CFG_ARM         = 3'd3,
    CFG_ESC_STOP    = 3'd4,
    CFG_ESC_RUN     = 3'd5,
    CFG_RELAY_LEVEL = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_ARMING     = 3'd0,
    PH_OFF        = 3'd1,
    PH_START_WAIT = 3'd2,
    PH_RUNNING    = 3'd3,
    PH_OFF_WAIT   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ticks;
    logic [DLY_W-1:0] on_delay_ticks;
    logic [DLY_W-1:0] off_delay_ticks;
    logic [DLY_W-1:0] arm_ticks;
    logic [PW_W-1:0]  esc_stop_width;
    logic [PW_W-1:0]  esc_run_width;
    logic             relay_active_level;
  } cfg_t;

  typedef struct packed {
    logic            relay_drive;
    logic [PW_W-1:0] esc_pulse_us;
    logic [2:0]      phase;
    logic            button_pressed;
  } res_t;

  // Counter step that stops at the top value.
  function automatic timer_t sat_inc(timer_t v);
    return (v == TMR_MAX) ? v : v + timer_t'(1);
  endfunction

endpackage

// ===== rtl/debounced_motor_relay_sequencer_core.sv =====
// Top level of the debounced motor relay sequencer.
// Depends on dmrs_pkg, dmrs_cfg_regs, dmrs_debounce and dmrs_sequencer.
//
// Usage:
// Each transfer on the input channel (in_valid/in_ready) is one millisecond
// tick carrying the raw button level. Each tick produces exactly one result
// on the output channel (out_valid/out_ready): relay pin level, ESC pulse
// width, phase code and debounced button level, all as they stand after
// that tick.
// The whole tick is evaluated in the cycle of its transfer; the sequencer
// and debouncer state update at that edge and the result is registered into
// the result register, or the skid entry during a stall. One tick per
// cycle is sustained while the receiver keeps up.
// The output side has a result register and one skid entry. A new tick is
// taken while a finished result waits; in_ready drops only when both are
// full, and results are never lost or reordered while the receiver stalls.
// Reset clears the result buffer, puts every configuration register at its
// default and restarts arming: for arm_ticks ticks the ESC is held at its
// stop width, the relay is open and the button is ignored.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata, one register per
// cycle; the user must write only while no tick is in flight, as the block does not enforce it.
module debounced_motor_relay_sequencer_core
  import dmrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  raw_button,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  relay_drive,
  output logic [PW_W-1:0]       esc_pulse_us,
  output logic [2:0]            phase,
  output logic                  button_pressed
);

  cfg_t            cfg;
  logic            in_accept;
  logic            arming;
  logic            level_next;
  phase_t          phase_next;
  logic            relay_closed;
  logic            esc_run;
  logic [PW_W-1:0] width_sel;
  res_t            res_new;
  res_t            out_res;
  res_t            skid_res;
  logic            out_valid_r;
  logic            skid_valid;

  // The input is held off only when the skid entry is occupied.
  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;

  dmrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The debouncer only runs on ticks that are not arming ticks.
  dmrs_debounce u_deb (
    .clk            (clk),
    .rst            (rst),
    .advance        (in_accept && !arming),
    .raw            (raw_button),
    .debounce_ticks (cfg.debounce_ticks),
    .level_next     (level_next)
  );

  dmrs_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (in_accept),
    .level      (level_next),
    .cfg        (cfg),
    .arming     (arming),
    .phase_next (phase_next)
  );

  // Pin levels follow the phase that the tick ends in. The relay is closed
  // only while running; the ESC runs in every phase from start-up through the
  // relay-off wait. The commanded width is clamped into the legal servo range.
  always_comb begin
    relay_closed = (phase_next == PH_RUNNING);
    esc_run      = (phase_next == PH_START_WAIT) || (phase_next == PH_RUNNING) ||
                   (phase_next == PH_OFF_WAIT);
    width_sel    = esc_run ? cfg.esc_run_width : cfg.esc_stop_width;
    res_new.relay_drive    = relay_closed ? cfg.relay_active_level
                                          : !cfg.relay_active_level;
    if (width_sel < ESC_W_MIN) begin
      res_new.esc_pulse_us = ESC_W_MIN;
    end else if (width_sel > ESC_W_MAX) begin
      res_new.esc_pulse_us = ESC_W_MAX;
    end else begin
      res_new.esc_pulse_us = width_sel;
    end
    res_new.phase          = phase_next;
    res_new.button_pressed = level_next;
  end

  // Result register plus one skid entry. A new result goes to the result
  // register when it is free or being drained this cycle, otherwise it parks
  // in the skid entry, which moves forward once the receiver takes a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (in_accept) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
        out_res     <= res_new;
      end else begin
        skid_valid  <= 1'b1;
        skid_res    <= res_new;
      end
    end else if (out_valid_r && out_ready) begin
      out_valid_r <= skid_valid;
      out_res     <= skid_res;
      skid_valid  <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign relay_drive    = out_res.relay_drive;
  assign esc_pulse_us   = out_res.esc_pulse_us;
  assign phase          = out_res.phase;
  assign button_pressed = out_res.button_pressed;

  // The skid entry is only ever filled behind an occupied result register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid_r)
    else $error("skid entry holds a result while the result register is empty");

  // Every offered pulse width lies inside the servo range.
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    out_valid_r |-> (esc_pulse_us >= ESC_W_MIN) && (esc_pulse_us <= ESC_W_MAX))
    else $error("ESC pulse width outside the legal range");

  // A tick that is not an arming tick never leaves the block in arming.
  a_no_rearm: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !arming) |-> (phase_next != PH_ARMING))
    else $error("sequencer returned to arming after arming ended");

endmodule

// ===== rtl/dmrs_cfg_regs.sv =====
// Configuration register file of the debounced motor relay sequencer.
// Depends on dmrs_pkg for the register codes, widths and reset values.
module dmrs_cfg_regs
  import dmrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= RST_DEBOUNCE;
      cfg.on_delay_ticks     <= RST_ON_DELAY;
      cfg.off_delay_ticks    <= RST_OFF_DELAY;
      cfg.arm_ticks          <= RST_ARM;
      cfg.esc_stop_width     <= RST_ESC_STOP;
      cfg.esc_run_width      <= RST_ESC_RUN;
      cfg.relay_active_level <= RST_RELAY_LVL;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:    cfg.debounce_ticks     <= cfg_wdata[DEB_W-1:0];
        CFG_ON_DELAY:    cfg.on_delay_ticks     <= cfg_wdata[DLY_W-1:0];
        CFG_OFF_DELAY:   cfg.off_delay_ticks    <= cfg_wdata[DLY_W-1:0];
        CFG_ARM:         cfg.arm_ticks          <= cfg_wdata[DLY_W-1:0];
        CFG_ESC_STOP:    cfg.esc_stop_width     <= cfg_wdata[PW_W-1:0];
        CFG_ESC_RUN:     cfg.esc_run_width      <= cfg_wdata[PW_W-1:0];
        CFG_RELAY_LEVEL: cfg.relay_active_level <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/dmrs_debounce.sv =====
// Button debouncer: last raw level, stable-time counter and accepted level.
// Depends on dmrs_pkg for the timer type and the saturating increment.
module dmrs_debounce
  import dmrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             raw,
  input  logic [DEB_W-1:0] debounce_ticks,
  output logic             level_next
);

  logic   last_raw;
  logic   level;
  timer_t tsc;
  timer_t tsc_next;
  logic   level_calc;

  always_comb begin
    // A change of the raw level restarts the stable-time count.
    tsc_next   = (raw != last_raw) ? '0 : sat_inc(tsc);
    level_calc = (cmp_t'(tsc_next) > cmp_t'(debounce_ticks)) ? raw : level;
    level_next = advance ? level_calc : level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw <= 1'b0;
      level    <= 1'b0;
      tsc      <= TMR_MAX;
    end else if (advance) begin
      last_raw <= raw;
      level    <= level_calc;
      tsc      <= tsc_next;
    end
  end

endmodule

// ===== rtl/dmrs_sequencer.sv =====
// Phase sequencer: arming timer, phase register and in-phase timer.
// Depends on dmrs_pkg for the phase codes, configuration struct and timers.
module dmrs_sequencer
  import dmrs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   step,
  input  logic   level,
  input  cfg_t   cfg,
  output logic   arming,
  output phase_t phase_next
);

  phase_t phase;
  timer_t tip;
  timer_t tip_next;
  timer_t tip_inc;
  timer_t arm_elapsed;
  timer_t arm_elapsed_next;

  always_comb begin
    arming           = (phase == PH_ARMING) &&
                       (cmp_t'(arm_elapsed) < cmp_t'(cfg.arm_ticks));
    tip_inc          = sat_inc(tip);
    phase_next       = phase;
    tip_next         = tip;
    arm_elapsed_next = arm_elapsed;
    if (arming) begin
      arm_elapsed_next = sat_inc(arm_elapsed);
    end else begin
      tip_next = tip_inc;
      unique case (phase)
        PH_START_WAIT: begin
          // A release during start-up drops straight back to off.
          if (!level) begin
            phase_next = PH_OFF;
          end else if (cmp_t'(tip_inc) >= cmp_t'(cfg.on_delay_ticks)) begin
            phase_next = PH_RUNNING;
          end
        end
        PH_RUNNING: begin
          if (!level) begin
            phase_next = PH_OFF_WAIT;
            tip_next   = '0;
          end
        end
        PH_OFF_WAIT: begin
          if (level) begin
            phase_next = PH_START_WAIT;
            tip_next   = '0;
          end else if (cmp_t'(tip_inc) >= cmp_t'(cfg.off_delay_ticks)) begin
            phase_next = PH_OFF;
          end
        end
        default: begin
          // Off, and the end of arming, which is handled as off on the same tick.
          if (level) begin
            phase_next = PH_START_WAIT;
            tip_next   = '0;
          end else begin
            phase_next = PH_OFF;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_ARMING;
      tip         <= '0;
      arm_elapsed <= '0;
    end else if (step) begin
      phase       <= phase_next;
      tip         <= tip_next;
      arm_elapsed <= arm_elapsed_next;
    end
  end

endmodule
